@@ rtl/utf8v_pkg.sv @@
package utf8v_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // register index of encoding_mode
  localparam logic [ADDR_W-3:0] REG_ENCODING_MODE = '0;

  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] HIGH_SUR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] HIGH_SUR_HI = 21'h00DBFF;
  localparam logic [CP_W-1:0] LOW_SUR_LO  = 21'h00DC00;
  localparam logic [CP_W-1:0] LOW_SUR_HI  = 21'h00DFFF;

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_BAD_LEAD = 3'd1,
    FAULT_BAD_CONT = 3'd2,
    FAULT_TRUNC    = 3'd3,
    FAULT_RANGE    = 3'd4,
    FAULT_PAIR     = 3'd5
  } fault_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_TWO   = 2'd1,
    CLS_THREE = 2'd2,
    CLS_FOUR  = 2'd3
  } len_class_t;

  typedef struct packed {
    logic [1:0]      pending_count;
    logic [CP_W-1:0] partial_code_point;
    len_class_t      length_class;
    logic            prev_high_surrogate;
    fault_t          fault_code;
  } strm_state_t;

  typedef struct packed {
    logic   well_formed;
    fault_t error_kind;
  } verdict_t;

  function automatic logic [CP_W-1:0] min_for_class(len_class_t cls);
    logic [CP_W-1:0] m;
    unique case (cls)
      CLS_TWO:   m = 21'h000080;
      CLS_THREE: m = 21'h000800;
      CLS_FOUR:  m = 21'h010000;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/utf8_cesu8_stream_validator.sv @@
// utf8 / cesu-8 stream validator
//
// input channel: one string byte per word (data_byte, last_byte), handshake
// in_valid / in_stall; the word is taken on a clock edge with in_valid high
// and in_stall low. strings are never empty.
// output channel: one verdict word per string (well_formed, error_kind),
// handshake out_valid / out_stall, issued for the word carrying last_byte.
// error_kind gives the first fault in byte order: 0 none, 1 bad lead,
// 2 bad continuation, 3 truncated, 4 overlong or out of range,
// 5 high surrogate followed by low surrogate.
// throughput: one byte per cycle while in_stall is low; the decode step is
// a single pass of logic between the string state registers and a two-word
// verdict queue. a verdict is queued on the edge that takes its last byte.
// stall: in_stall rises only when both verdict slots are occupied; bytes
// without last_byte still need a free slot, so the queue depth sets that.
// apb: encoding_mode at byte address 0 (0 utf-8, 1 cesu-8), pready always
// high; write it only while the block is idle.
// reset (rst, synchronous): string state and queue cleared, mode set to utf-8.
module utf8_cesu8_stream_validator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [utf8v_pkg::ADDR_W-1:0]   paddr,
  input  logic [utf8v_pkg::DATA_W-1:0]   pwdata,
  output logic [utf8v_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           well_formed,
  output logic [2:0]                     error_kind
);
  import utf8v_pkg::*;

  logic        encoding_mode;
  strm_state_t st;
  strm_state_t st_next;
  verdict_t    verdict;
  verdict_t    out_data;
  logic        in_accept;
  logic        q_full;
  logic        reg_hit;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[ADDR_W-1:2] == REG_ENCODING_MODE);
  assign prdata    = reg_hit ? {{(DATA_W-1){1'b0}}, encoding_mode} : '0;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      encoding_mode <= pwdata[0];
    end
  end

  // per-string state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  utf8v_decode u_decode (
    .st        (st),
    .cesu      (encoding_mode),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .st_next   (st_next),
    .verdict   (verdict)
  );

  // verdicts wait here; bytes flow under out_stall until the queue fills
  utf8v_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && last_byte),
    .push_data (verdict),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign well_formed = out_data.well_formed;
  assign error_kind  = out_data.error_kind;

endmodule

@@ rtl/utf8v_decode.sv @@
module utf8v_decode (
  input  utf8v_pkg::strm_state_t st,
  input  logic                   cesu,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output utf8v_pkg::strm_state_t st_next,
  output utf8v_pkg::verdict_t    verdict
);
  import utf8v_pkg::*;

  logic [CP_W-1:0] cp_acc;
  strm_state_t     nx;
  fault_t          fin_fault;

  assign cp_acc = {st.partial_code_point[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    nx = st;
    if (st.fault_code == FAULT_NONE) begin
      if (st.pending_count == 2'd0) begin
        priority if (!data_byte[7]) begin
          nx.prev_high_surrogate = 1'b0;
        end else if (data_byte[7:5] == 3'b110) begin
          nx.pending_count      = 2'd1;
          nx.length_class       = CLS_TWO;
          nx.partial_code_point = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        end else if (data_byte[7:4] == 4'b1110) begin
          nx.pending_count      = 2'd2;
          nx.length_class       = CLS_THREE;
          nx.partial_code_point = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        end else if (data_byte[7:3] == 5'b11110 && !cesu) begin
          nx.pending_count      = 2'd3;
          nx.length_class       = CLS_FOUR;
          nx.partial_code_point = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        end else begin
          nx.fault_code = FAULT_BAD_LEAD;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        nx.fault_code = FAULT_BAD_CONT;
      end else begin
        nx.pending_count      = st.pending_count - 2'd1;
        nx.partial_code_point = cp_acc;
        if (st.pending_count == 2'd1) begin
          // character complete: range then surrogate pairing
          nx.partial_code_point = '0;
          nx.length_class       = CLS_NONE;
          priority if (cp_acc < min_for_class(st.length_class) ||
                       (!cesu && cp_acc > CP_MAX)) begin
            nx.fault_code = FAULT_RANGE;
          end else if (cesu) begin
            nx.prev_high_surrogate = 1'b0;
          end else if (cp_acc >= HIGH_SUR_LO && cp_acc <= HIGH_SUR_HI) begin
            nx.prev_high_surrogate = 1'b1;
          end else if (cp_acc >= LOW_SUR_LO && cp_acc <= LOW_SUR_HI &&
                       st.prev_high_surrogate) begin
            nx.fault_code = FAULT_PAIR;
          end else begin
            nx.prev_high_surrogate = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    if (nx.fault_code == FAULT_NONE && nx.pending_count != 2'd0) begin
      fin_fault = FAULT_TRUNC;
    end else begin
      fin_fault = nx.fault_code;
    end
    verdict.well_formed = (fin_fault == FAULT_NONE);
    verdict.error_kind  = fin_fault;
    if (last_byte) begin
      st_next = '0;
    end else begin
      st_next = nx;
    end
  end

endmodule

@@ rtl/utf8v_out_queue.sv @@
module utf8v_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utf8v_pkg::verdict_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output utf8v_pkg::verdict_t out_data
);
  import utf8v_pkg::*;

  verdict_t   q0;
  verdict_t   q1;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop       = (count != 2'd0) && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = q0;

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      q0 <= q1;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      q0 <= push_data;
    end
    if (push && count == 2'd1 && !pop) begin
      q1 <= push_data;
    end
  end

endmodule

@@ rtl/utf8v_checker.sv @@
module utf8v_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         last_byte,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         well_formed,
  input logic [2:0]                   error_kind
);
  import utf8v_pkg::*;

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(well_formed) && $stable(error_kind))
    else $error("verdict changed under stall");

  // verdict bit agrees with the fault code
  a_wf_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (well_formed == (error_kind == FAULT_NONE)))
    else $error("well_formed disagrees with error_kind");

  // only defined fault codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_kind <= FAULT_PAIR))
    else $error("undefined error code");

  // a taken last byte always yields a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("no verdict after last byte");

  // queue empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict present after reset");

endmodule

bind utf8_cesu8_stream_validator utf8v_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .well_formed (well_formed),
  .error_kind  (error_kind)
);

@@ bench/utf8v_verdict_checker.sv @@
`timescale 1ns / 100ps

module utf8v_verdict_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [utf8v_pkg::ADDR_W-1:0] paddr,
  input  logic [utf8v_pkg::DATA_W-1:0] pwdata,
  input  logic                         pready,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         well_formed,
  input  logic [2:0]                   error_kind,
  output int unsigned                  fail_count,
  output int unsigned                  verdicts_waiting
);
  import utf8v_pkg::*;

  localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * int'(REG_ENCODING_MODE));

  // shadow of the mode register and of the per-string decode state
  logic            cesu_mode;
  logic [1:0]      cont_left;
  logic [CP_W-1:0] cp_acc;
  len_class_t      seq_class;
  logic            high_seen;
  fault_t          first_fault;

  verdict_t        pending_verdicts[$];
  verdict_t        want;

  task automatic clear_string();
    cont_left   = '0;
    cp_acc      = '0;
    seq_class   = CLS_NONE;
    high_seen   = 1'b0;
    first_fault = FAULT_NONE;
  endtask

  // range and surrogate rules once the last continuation byte is in
  task automatic close_char(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] floor_cp;
    case (seq_class)
      CLS_TWO:   floor_cp = 21'h000080;
      CLS_THREE: floor_cp = 21'h000800;
      CLS_FOUR:  floor_cp = 21'h010000;
      default:   floor_cp = '0;
    endcase
    if (cp < floor_cp || (!cesu_mode && cp > CP_MAX)) begin
      first_fault = FAULT_RANGE;
    end else if (cesu_mode) begin
      high_seen = 1'b0;
    end else if (cp >= HIGH_SUR_LO && cp <= HIGH_SUR_HI) begin
      high_seen = 1'b1;
    end else if (cp >= LOW_SUR_LO && cp <= LOW_SUR_HI && high_seen) begin
      first_fault = FAULT_PAIR;
    end else begin
      high_seen = 1'b0;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        high_seen = 1'b0;
      end else if (b[7:5] == 3'b110) begin
        cont_left = 2'd1;
        seq_class = CLS_TWO;
        cp_acc    = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        cont_left = 2'd2;
        seq_class = CLS_THREE;
        cp_acc    = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110 && !cesu_mode) begin
        cont_left = 2'd3;
        seq_class = CLS_FOUR;
        cp_acc    = CP_W'(b[2:0]);
      end else begin
        first_fault = FAULT_BAD_LEAD;
      end
    end else if (b[7:6] != 2'b10) begin
      first_fault = FAULT_BAD_CONT;
    end else begin
      cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        close_char(cp_acc);
        cp_acc    = '0;
        seq_class = CLS_NONE;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cesu_mode = 1'b0;
      clear_string();
      pending_verdicts.delete();
      fail_count = 0;
    end else begin
      // verdict words leaving the block
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: verdict with none expected, got well_formed %0d error_kind %0d",
                   $time, well_formed, error_kind);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (well_formed !== want.well_formed) begin
            $display("%0t: well_formed mismatch, expected %0d, got %0d",
                     $time, want.well_formed, well_formed);
            fail_count++;
          end
          if (error_kind !== want.error_kind) begin
            $display("%0t: error_kind mismatch, expected %0d, got %0d",
                     $time, want.error_kind, error_kind);
            fail_count++;
          end
        end
      end
      // string bytes entering the block
      if (in_valid && !in_stall) begin
        if (first_fault == FAULT_NONE) scan_byte(data_byte);
        if (last_byte) begin
          if (first_fault == FAULT_NONE && cont_left != 2'd0) first_fault = FAULT_TRUNC;
          want.well_formed = (first_fault == FAULT_NONE);
          want.error_kind  = first_fault;
          pending_verdicts.push_back(want);
          clear_string();
        end
      end
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) cesu_mode = pwdata[0];
    end
    verdicts_waiting = pending_verdicts.size();
  end

endmodule

@@ bench/tb_utf8_cesu8_stream_validator.sv @@
`timescale 1ns / 100ps

module tb_utf8_cesu8_stream_validator;
  import utf8v_pkg::*;

  // register address and the two encoding settings
  localparam logic [ADDR_W-1:0] MODE_ADDR  = ADDR_W'(4 * int'(REG_ENCODING_MODE));
  localparam logic [DATA_W-1:0] MODE_UTF8  = '0;
  localparam logic [DATA_W-1:0] MODE_CESU8 = DATA_W'(1);

  // cycles with no word moving on either channel before the run is called hung
  localparam int unsigned STUCK_LIMIT = 3000;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 400;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic              well_formed;
  logic [2:0]        error_kind;

  int unsigned fail_count;
  int unsigned verdicts_waiting;
  int unsigned stuck_cycles;

  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit calm;
  bit hold_req;

  // string being built and sent
  logic [7:0] str_bytes[$];

  utf8_cesu8_stream_validator u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .well_formed (well_formed),
    .error_kind  (error_kind)
  );

  // watches both channels and the register port, predicts and compares
  utf8v_verdict_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .well_formed      (well_formed),
    .error_kind       (error_kind),
    .fail_count       (fail_count),
    .verdicts_waiting (verdicts_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang detector: counts cycles in which no word is taken on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // verdict receiver: random stalls, none while calm, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 13);
      end
    end
  end

  // offer one byte, maybe after a few idle cycles, and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // let every verdict come back, give the block a few cycles, then write the mode
  task automatic switch_mode(input logic [DATA_W-1:0] mode);
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_waiting != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= mode;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // encode a code point in the given number of bytes, overlong forms allowed
  task automatic put_char(input int unsigned code, input int nbytes);
    logic [20:0] c;
    c = code[20:0];
    case (nbytes)
      1: str_bytes.push_back({1'b0, c[6:0]});
      2: begin
        str_bytes.push_back({3'b110, c[10:6]});
        str_bytes.push_back({2'b10, c[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, c[15:12]});
        str_bytes.push_back({2'b10, c[11:6]});
        str_bytes.push_back({2'b10, c[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, c[20:18]});
        str_bytes.push_back({2'b10, c[17:12]});
        str_bytes.push_back({2'b10, c[11:6]});
        str_bytes.push_back({2'b10, c[5:0]});
      end
    endcase
  endtask

  // mostly well-formed strings with random content, some broken on purpose
  task automatic build_string(input bit cesu);
    int unsigned pick;
    int          n;
    int          pos;
    str_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        put_char($urandom_range(0, 'h7F), 1);
      end else if (pick < 48) begin
        put_char($urandom_range('h80, 'h7FF), 2);
      end else if (pick < 66) begin
        put_char($urandom_range('h800, 'hFFFF), 3);
      end else if (pick < 86) begin
        // supplementary character: four bytes, or a surrogate pair, which
        // cesu-8 accepts and utf-8 rejects
        if (!cesu && pick < 76) begin
          put_char($urandom_range('h10000, 'h10FFFF), 4);
        end else begin
          put_char($urandom_range('hD800, 'hDBFF), 3);
          put_char($urandom_range('hDC00, 'hDFFF), 3);
        end
      end else if (pick < 91) begin
        // lone surrogate, high or low
        put_char($urandom_range('hD800, 'hDFFF), 3);
      end else if (pick < 95) begin
        // overlong form
        n = $urandom_range(2, 4);
        put_char($urandom_range(0, n == 2 ? 'h7F : n == 3 ? 'h7FF : 'hFFFF), n);
      end else if (pick < 97) begin
        // beyond the top of the code space, or a four-byte lead in cesu-8
        put_char($urandom_range('h110000, 'h1FFFFF), 4);
      end else begin
        str_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // break a fifth of them: clobber a byte, cut the tail or slip in a stray byte
    if ($urandom_range(99) < 20) begin
      pos = $urandom_range(0, str_bytes.size() - 1);
      case ($urandom_range(2))
        0: str_bytes[pos] = 8'($urandom_range(0, 255));
        1: if (str_bytes.size() > 1) str_bytes.pop_back();
        default: str_bytes.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] mode, input int budget,
                           input bit quiet, input bit squeeze);
    int sent;
    sent = 0;
    switch_mode(mode);
    calm     = quiet;
    hold_req = squeeze;
    while (sent < budget) begin
      build_string(mode == MODE_CESU8);
      sent += str_bytes.size();
      send_string();
    end
    calm = 1'b0;
  endtask

  initial begin
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // utf-8 corner cases
    switch_mode(MODE_UTF8);
    str_bytes = {8'h00};                                      send_string();
    str_bytes = {8'hFF};                                      send_string();
    str_bytes = {8'hC2, 8'h80};                               send_string();
    // overlong two-byte form
    str_bytes = {8'hC0, 8'h80};                               send_string();
    // ascii where a continuation byte belongs
    str_bytes = {8'hE0, 8'h41};                               send_string();
    // string ends inside a sequence
    str_bytes = {8'hE2, 8'h82};                               send_string();
    // final byte is itself a bad continuation: that wins over truncation
    str_bytes = {8'hC3, 8'hFF};                               send_string();
    // largest code point, then one past it
    str_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};                 send_string();
    str_bytes = {8'hF4, 8'h90, 8'h80, 8'h80};                 send_string();
    // high surrogate directly followed by low surrogate
    str_bytes = {8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80};   send_string();

    // cesu-8: four-byte leads are bad, surrogate pairs are fine
    switch_mode(MODE_CESU8);
    str_bytes = {8'hF0, 8'h80};                               send_string();
    str_bytes = {8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80};   send_string();

    // random strings; first phase runs with no idling, third backs the block up
    run_phase(MODE_UTF8,  220, 1'b1, 1'b0);
    run_phase(MODE_CESU8, 200, 1'b0, 1'b0);
    run_phase(MODE_UTF8,  220, 1'b0, 1'b1);
    run_phase(MODE_CESU8, 200, 1'b0, 1'b0);

    // drain, then a short grace period for any stray verdict
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_waiting != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/utf8v_pkg.sv
rtl/utf8v_decode.sv
rtl/utf8v_out_queue.sv
rtl/utf8_cesu8_stream_validator.sv
rtl/utf8v_checker.sv
bench/utf8v_verdict_checker.sv
bench/tb_utf8_cesu8_stream_validator.sv
